/* rtl/core/lslf_pkg.sv */
// Shared types and constants of the least-squares line fit core.
// Used by all modules in rtl/core; no dependencies.
package lslf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SX_W       = SAMPLE_W + CNT_W - 1;
    localparam int SXX_W      = 2 * SAMPLE_W + CNT_W - 2;
    localparam int SXY_W      = SXX_W + 1;
    localparam int MCAND_W    = SXY_W;
    localparam int MPLIER_W   = SX_W;
    localparam int PROD_W     = MCAND_W + MPLIER_W;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int DVD_W      = PROD_W + FRAC_BITS;
    localparam int RES_W      = 48;
    localparam int SPREAD_W   = 16;
    localparam int MUL_STEPS  = MPLIER_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int MCNT_W     = $clog2(MUL_STEPS);
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    // sums of one finished point set
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SX_W-1:0]  sx;
        logic signed [SX_W-1:0]  sy;
        logic [SXX_W-1:0]        sxx;
        logic signed [SXY_W-1:0] sxy;
        logic                    ovf;
    } snap_t;

    typedef enum logic [2:0] {
        MUL_N_SXX,
        MUL_SX_SX,
        MUL_N_SXY,
        MUL_SX_SY,
        MUL_SXX_SY,
        MUL_SX_SXY
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MLOAD,
        ST_MRUN,
        ST_DLOAD,
        ST_DRUN,
        ST_OUT
    } fit_state_t;

endpackage

/* rtl/core/lslf_front.sv */
// Front end: takes point beats, keeps the running sums, hands a snapshot
// to the queue on the last point of a set. Depends on lslf_pkg.
module lslf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lslf_pkg::SAMPLE_W-1:0] x_value,
    input  logic signed [lslf_pkg::SAMPLE_W-1:0] y_value,
    input  logic                                last_point,
    input  logic                                q_full,
    output logic                                push,
    output lslf_pkg::snap_t                     snap
);
    import lslf_pkg::*;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SX_W-1:0]  sx_reg, sx_next;
    logic signed [SX_W-1:0]  sy_reg, sy_next;
    logic [SXX_W-1:0]        sxx_reg, sxx_next;
    logic signed [SXY_W-1:0] sxy_reg, sxy_next;
    logic                    ovf_reg, ovf_next;
    logic                    take, room;
    logic signed [2*SAMPLE_W-1:0] xx, xy;

    assign in_stall = q_full;
    assign take     = in_valid && !in_stall;
    assign room     = cnt_reg < CNT_W'(MAX_POINTS);
    assign xx       = x_value * x_value;
    assign xy       = x_value * y_value;

    always_comb
    begin
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxx_next = sxx_reg;
        sxy_next = sxy_reg;
        ovf_next = ovf_reg;
        if (room)
        begin
            cnt_next = cnt_reg + 1'b1;
            sx_next  = sx_reg + SX_W'(x_value);
            sy_next  = sy_reg + SX_W'(y_value);
            sxx_next = sxx_reg + SXX_W'($unsigned(xx));
            sxy_next = sxy_reg + SXY_W'(xy);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign push       = take && last_point;
    assign snap.count = cnt_next;
    assign snap.sx    = sx_next;
    assign snap.sy    = sy_next;
    assign snap.sxx   = sxx_next;
    assign snap.sxy   = sxy_next;
    assign snap.ovf   = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last_point)
            begin
                cnt_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxx_reg <= '0;
                sxy_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sx_reg  <= sx_next;
                sy_reg  <= sy_next;
                sxx_reg <= sxx_next;
                sxy_reg <= sxy_next;
                ovf_reg <= ovf_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");
`endif

endmodule

/* rtl/core/lslf_queue.sv */
// Short snapshot queue between front and back end.
// Depends on lslf_pkg.
module lslf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lslf_pkg::snap_t wdata,
    input  logic            pop,
    output lslf_pkg::snap_t rdata,
    output logic            full,
    output logic            empty
);
    import lslf_pkg::*;

    snap_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_W:0]     fill_reg, fill_next;

    assign full  = fill_reg == (QPTR_W+1)'(QDEPTH);
    assign empty = fill_reg == '0;
    assign rdata = mem_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        fill_next = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* rtl/core/lslf_back.sv */
// Back end: shift-add multiplier and restoring divider run by a sequencer,
// producing slope and intercept into an output register. Depends on lslf_pkg.
module lslf_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lslf_pkg::SPREAD_W-1:0]      min_spread,
    input  logic                               q_empty,
    input  lslf_pkg::snap_t                    q_data,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [lslf_pkg::RES_W-1:0]  slope,
    output logic signed [lslf_pkg::RES_W-1:0]  intercept,
    output logic                               fit_valid,
    output logic                               overflowed,
    output logic [lslf_pkg::CNT_W-1:0]         points_used
);
    import lslf_pkg::*;

    fit_state_t state_reg, state_next;
    mul_op_t    op_reg, op_next;
    snap_t      snap_reg;

    logic [PROD_W-1:0]         mcand_reg, mcand_next, acc_reg, acc_next;
    logic [MPLIER_W-1:0]       mplier_reg, mplier_next;
    logic                      mneg_reg, mneg_next;
    logic [MCNT_W-1:0]         mcnt_reg, mcnt_next;
    logic signed [PROD_W-1:0]  hold_reg, hold_next, prod;
    logic signed [DIFF_W-1:0]  den_reg, den_next, numm_reg, numm_next;
    logic signed [DIFF_W-1:0]  numb_reg, numb_next, diff, num_sel;
    logic [DVD_W-1:0]          dvd_reg, dvd_next;
    logic [DIFF_W-1:0]         rem_reg, rem_next, rem_sh;
    logic                      dneg_reg, dneg_next, dsel_reg, dsel_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic signed [RES_W-1:0]   m_reg, m_next, b_reg, b_next, sat;
    logic                      fv_reg, fv_next;
    logic                      mul_done, div_done, degen, ge, load_out;
    logic signed [MCAND_W-1:0] opa;
    logic signed [MPLIER_W-1:0] opb;
    logic [MCAND_W-1:0]        opa_mag;
    logic [MPLIER_W-1:0]       opb_mag;
    logic [PROD_W-1:0]         num_mag;
    logic [DVD_W-1:0]          limit;
    logic [RES_W-1:0]          qval;

    logic                      ov_reg;
    logic signed [RES_W-1:0]   slope_reg, icpt_reg;
    logic                      fitv_reg, ovfo_reg;
    logic [CNT_W-1:0]          used_reg;

    // operand pick per product
    always_comb
    begin
        case (op_reg)
            MUL_N_SXX:
            begin
                opa = $signed({1'b0, snap_reg.sxx});
                opb = $signed(MPLIER_W'(snap_reg.count));
            end
            MUL_SX_SX:
            begin
                opa = MCAND_W'(snap_reg.sx);
                opb = snap_reg.sx;
            end
            MUL_N_SXY:
            begin
                opa = snap_reg.sxy;
                opb = $signed(MPLIER_W'(snap_reg.count));
            end
            MUL_SX_SY:
            begin
                opa = MCAND_W'(snap_reg.sx);
                opb = snap_reg.sy;
            end
            MUL_SXX_SY:
            begin
                opa = $signed({1'b0, snap_reg.sxx});
                opb = snap_reg.sy;
            end
            MUL_SX_SXY:
            begin
                opa = snap_reg.sxy;
                opb = snap_reg.sx;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        opa_mag = opa[MCAND_W-1] ? (~opa + 1'b1) : opa;
        opb_mag = opb[MPLIER_W-1] ? (~opb + 1'b1) : opb;
    end

    assign mul_done = (state_reg == ST_MRUN) && (mcnt_reg == MCNT_W'(MUL_STEPS - 1));
    assign div_done = (state_reg == ST_DRUN) && (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign acc_next = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign prod     = mneg_reg ? $signed(~acc_next + 1'b1) : $signed(acc_next);
    assign diff     = DIFF_W'(hold_reg) - DIFF_W'(prod);
    assign degen    = diff[DIFF_W-1] ||
                      (diff[DIFF_W-2:0] <= (DIFF_W-1)'(min_spread));

    assign num_sel  = dsel_reg ? numb_reg : numm_reg;
    assign num_mag  = PROD_W'(num_sel[DIFF_W-1] ? (~num_sel + 1'b1) : num_sel);
    assign rem_sh   = {rem_reg[DIFF_W-2:0], dvd_reg[DVD_W-1]};
    assign ge       = rem_sh >= $unsigned(den_reg);
    assign dvd_next = {dvd_reg[DVD_W-2:0], ge};
    assign limit    = dneg_reg ? (DVD_W'(1) << (RES_W - 1))
                               : ((DVD_W'(1) << (RES_W - 1)) - 1'b1);
    assign qval     = (dvd_next > limit) ? limit[RES_W-1:0] : dvd_next[RES_W-1:0];
    assign sat      = dneg_reg ? $signed(~qval + 1'b1) : $signed(qval);
    assign load_out = (state_reg == ST_OUT) && (!ov_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_MLOAD;
            ST_MLOAD: state_next = ST_MRUN;
            ST_MRUN:
                if (mul_done)
                begin
                    if (op_reg == MUL_SX_SX && degen)
                        state_next = ST_OUT;
                    else if (op_reg == MUL_SX_SXY)
                        state_next = ST_DLOAD;
                    else
                        state_next = ST_MLOAD;
                end
            ST_DLOAD: state_next = ST_DRUN;
            ST_DRUN:
                if (div_done)
                    state_next = dsel_reg ? ST_OUT : ST_DLOAD;
            ST_OUT:   if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        pop         = 1'b0;
        op_next     = op_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        mneg_next   = mneg_reg;
        mcnt_next   = mcnt_reg;
        hold_next   = hold_reg;
        den_next    = den_reg;
        numm_next   = numm_reg;
        numb_next   = numb_reg;
        rem_next    = rem_reg;
        dneg_next   = dneg_reg;
        dsel_next   = dsel_reg;
        dcnt_next   = dcnt_reg;
        m_next      = m_reg;
        b_next      = b_reg;
        fv_next     = fv_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pop     = !q_empty;
                op_next = MUL_N_SXX;
            end
            ST_MLOAD:
            begin
                mcand_next  = PROD_W'(opa_mag);
                mplier_next = opb_mag;
                mneg_next   = opa[MCAND_W-1] ^ opb[MPLIER_W-1];
                mcnt_next   = '0;
            end
            ST_MRUN:
            begin
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                mcnt_next   = mcnt_reg + 1'b1;
                if (mul_done)
                begin
                    op_next = mul_op_t'(op_reg + 3'd1);
                    case (op_reg)
                        MUL_SX_SX:
                        begin
                            den_next = diff;
                            fv_next  = !degen;
                            m_next   = '0;
                            b_next   = '0;
                        end
                        MUL_SX_SY:  numm_next = diff;
                        MUL_SX_SXY:
                        begin
                            numb_next = diff;
                            dsel_next = 1'b0;
                        end
                        default:    hold_next = prod;
                    endcase
                end
            end
            ST_DLOAD:
            begin
                rem_next  = '0;
                dneg_next = num_sel[DIFF_W-1];
                dcnt_next = '0;
            end
            ST_DRUN:
            begin
                rem_next  = ge ? rem_sh - $unsigned(den_reg) : rem_sh;
                dcnt_next = dcnt_reg + 1'b1;
                if (div_done)
                begin
                    if (dsel_reg)
                        b_next = sat;
                    else
                        m_next = sat;
                    dsel_next = 1'b1;
                end
            end
            ST_OUT:   ;
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            snap_reg <= q_data;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        mneg_reg   <= mneg_next;
        hold_reg   <= hold_next;
        den_reg    <= den_next;
        numm_reg   <= numm_next;
        numb_reg   <= numb_next;
        rem_reg    <= rem_next;
        dneg_reg   <= dneg_next;
        dsel_reg   <= dsel_next;
        m_reg      <= m_next;
        b_reg      <= b_next;
        fv_reg     <= fv_next;
        if (state_reg == ST_MLOAD)
            acc_reg <= '0;
        else if (state_reg == ST_MRUN)
            acc_reg <= acc_next;
        if (state_reg == ST_DLOAD)
            dvd_reg <= {num_mag, FRAC_BITS'(0)};
        else if (state_reg == ST_DRUN)
            dvd_reg <= dvd_next;
        if (load_out)
        begin
            slope_reg <= m_reg;
            icpt_reg  <= b_reg;
            fitv_reg  <= fv_reg;
            ovfo_reg  <= snap_reg.ovf;
            used_reg  <= snap_reg.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= MUL_N_SXX;
            mcnt_reg  <= '0;
            dcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            mcnt_reg  <= mcnt_next;
            dcnt_reg  <= dcnt_next;
            if (load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid   = ov_reg;
    assign slope       = slope_reg;
    assign intercept   = icpt_reg;
    assign fit_valid   = fitv_reg;
    assign overflowed  = ovfo_reg;
    assign points_used = used_reg;

`ifndef SYNTHESIS
    a_div_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRUN) |-> (!den_reg[DIFF_W-1] && den_reg != '0))
        else $error("divider running on non-positive spread");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !fitv_reg) |-> (slope_reg == '0 && icpt_reg == '0))
        else $error("degenerate fit with nonzero result");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_MLOAD && op_reg == MUL_N_SXX))
        else $error("snapshot taken outside idle");
`endif

endmodule

/* rtl/core/least_squares_line_fit_core.sv */
// Top level of the streaming least-squares line fit.
// Depends on lslf_pkg, lslf_front, lslf_queue and lslf_back.

// Points are taken one beat per clock and summed at once. The beat marked
// last closes the set: its sums go into a two-entry queue and the sums clear,
// so the next set streams in while the fit runs. The fit uses one shift-add
// multiplier (up to six products) and one restoring divider (two quotients);
// input stalls only when two finished sets are still waiting for the fit
// unit. Slope and intercept are signed Q32.16, truncated toward zero and
// saturated; when n*Sxx - Sx^2 is at most min_spread both are zero and
// fit_valid is low.
module least_squares_line_fit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [lslf_pkg::SPREAD_W-1:0]        cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [lslf_pkg::SAMPLE_W-1:0] x_value,
    input  logic signed [lslf_pkg::SAMPLE_W-1:0] y_value,
    input  logic                                 last_point,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lslf_pkg::RES_W-1:0]    slope,
    output logic signed [lslf_pkg::RES_W-1:0]    intercept,
    output logic                                 fit_valid,
    output logic                                 overflowed,
    output logic [lslf_pkg::CNT_W-1:0]           points_used
);
    import lslf_pkg::*;

    logic [SPREAD_W-1:0] min_spread_reg;
    logic                q_full, q_empty, push, pop;
    snap_t               snap_in, snap_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_spread_reg <= '0;
        else if (cfg_write_en)
            min_spread_reg <= cfg_write_data;
    end

    lslf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_value    (x_value),
        .y_value    (y_value),
        .last_point (last_point),
        .q_full     (q_full),
        .push       (push),
        .snap       (snap_in)
    );

    lslf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (snap_in),
        .pop   (pop),
        .rdata (snap_out),
        .full  (q_full),
        .empty (q_empty)
    );

    lslf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_spread  (min_spread_reg),
        .q_empty     (q_empty),
        .q_data      (snap_out),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slope       (slope),
        .intercept   (intercept),
        .fit_valid   (fit_valid),
        .overflowed  (overflowed),
        .points_used (points_used)
    );

endmodule
